// ===== rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console character writer
// Command codes, control characters, port field widths and the controller to
// datapath command and status groups.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEFAULT_SCREEN_WIDTH  = 80;
    localparam int DEFAULT_SCREEN_HEIGHT = 25;

    localparam int COLOR_W    = 8;
    localparam int CHAR_W     = 8;
    localparam int POS_IN_W   = 8;
    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;
    localparam int LIN_OUT_W  = 11;
    localparam int CELL_W     = 16;
    localparam int CMD_W      = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
    localparam logic [CELL_W-1:0]  RESET_CELL  = 16'h0720;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // What the sweep does with the cell under the scan pointer this cycle
    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_COPY,
        STEP_BLANK,
        STEP_INIT
    } step_t;

    typedef enum logic [1:0] {
        LOAD_NONE,
        LOAD_ZERO,
        LOAD_ROW1,
        LOAD_LAST_ROW
    } scan_load_t;

    typedef struct packed {
        logic       accept;
        logic       exec;
        logic       read_cell;
        logic       load_out;
        step_t      step;
        scan_load_t load;
    } ctl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic need_scroll;
        logic is_clear;
        logic read_hit;
    } dp_status_t;

endpackage

// ===== rtl/tcw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath: cursor, screen store and result register
// Holds the cursor and its linear address, the cell memory with a one-deep
// write queue, the scan pointer used by scroll, clear and the reset pass.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int SCREEN_WIDTH  = tcw_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tcw_pkg::DEFAULT_SCREEN_HEIGHT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [tcw_pkg::COLOR_W-1:0]      cfg_data,
    input  tcw_pkg::cmd_t                    in_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]       in_char,
    input  logic [tcw_pkg::POS_IN_W-1:0]     in_col,
    input  logic [tcw_pkg::POS_IN_W-1:0]     in_row,
    input  tcw_pkg::ctl_cmd_t                ctl,
    output tcw_pkg::dp_status_t              sts,
    output logic [tcw_pkg::COL_OUT_W-1:0]    cursor_col_out,
    output logic [tcw_pkg::ROW_OUT_W-1:0]    cursor_row_out,
    output logic [tcw_pkg::LIN_OUT_W-1:0]    cursor_linear,
    output logic [tcw_pkg::CELL_W-1:0]       cell_data,
    output logic                             scrolled
);

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(SCREEN_WIDTH);
    localparam int RW    = $clog2(SCREEN_HEIGHT);
    localparam int CXW   = (CW > tcw_pkg::COL_OUT_W) ? CW : tcw_pkg::COL_OUT_W;
    localparam int RXW   = (RW > tcw_pkg::ROW_OUT_W) ? RW : tcw_pkg::ROW_OUT_W;
    localparam int LXW   = (AW > tcw_pkg::LIN_OUT_W) ? AW : tcw_pkg::LIN_OUT_W;
    localparam int PW    = 2 * tcw_pkg::POS_IN_W;

    logic [tcw_pkg::CELL_W-1:0] mem [CELLS];

    logic [tcw_pkg::COLOR_W-1:0]  color_reg;
    logic [CW-1:0]                col_reg, col_next;
    logic [RW-1:0]                line_reg, line_next;
    logic [AW-1:0]                lin_reg, lin_next;
    tcw_pkg::cmd_t                cmd_reg;
    logic [tcw_pkg::CHAR_W-1:0]   char_reg;
    logic [tcw_pkg::POS_IN_W-1:0] colin_reg, rowin_reg;
    logic                         scrolled_reg;
    logic [AW-1:0]                scan_reg, scan_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [AW-1:0]                pend_addr_reg, pend_addr_next;
    logic                         pend_copy_reg, pend_copy_next;
    logic [tcw_pkg::CELL_W-1:0]   pend_data_reg, pend_data_next;
    logic [tcw_pkg::CELL_W-1:0]   rd_data_reg;

    logic [tcw_pkg::COL_OUT_W-1:0] out_col_reg;
    logic [tcw_pkg::ROW_OUT_W-1:0] out_row_reg;
    logic [tcw_pkg::LIN_OUT_W-1:0] out_lin_reg;
    logic [tcw_pkg::CELL_W-1:0]    out_cell_reg;
    logic                          out_scrolled_reg;

    logic                         in_range;
    logic [PW-1:0]                pos_lin;
    logic [AW-1:0]                pos_addr;
    logic [8:0]                   tab_sum;
    logic [CW-1:0]                put_col;
    logic                         put_inc;
    logic                         put_wr;
    logic [AW-1:0]                put_addr;
    logic [tcw_pkg::CHAR_W-1:0]   put_ch;
    logic                         need_scroll;
    logic [RW-1:0]                put_line;
    logic [AW:0]                  put_lin;
    logic [CXW-1:0]               col_ext;
    logic [RXW-1:0]               row_ext;
    logic [LXW-1:0]               lin_ext;

    assign in_range = ({1'b0, colin_reg} < 9'(SCREEN_WIDTH))
                   && ({1'b0, rowin_reg} < 9'(SCREEN_HEIGHT));
    assign pos_lin  = PW'(rowin_reg) * PW'(SCREEN_WIDTH) + PW'(colin_reg);
    assign pos_addr = pos_lin[AW-1:0];
    assign tab_sum  = (9'(col_reg) + 9'd8) & ~9'd7;

    // Put: control characters and ordinary writes
    always_comb
    begin
        put_col  = col_reg;
        put_inc  = 1'b0;
        put_wr   = 1'b0;
        put_addr = lin_reg;
        put_ch   = char_reg;
        unique case (char_reg)
            tcw_pkg::CH_LF:
            begin
                put_col = '0;
                put_inc = 1'b1;
            end
            tcw_pkg::CH_CR:
            begin
                put_col = '0;
            end
            tcw_pkg::CH_TAB:
            begin
                if (tab_sum >= 9'(SCREEN_WIDTH))
                begin
                    put_col = '0;
                    put_inc = 1'b1;
                end
                else
                begin
                    put_col = CW'(tab_sum);
                end
            end
            tcw_pkg::CH_BS:
            begin
                // no-op at column zero
                if (col_reg != '0)
                begin
                    put_col  = col_reg - CW'(1);
                    put_wr   = 1'b1;
                    put_addr = lin_reg - AW'(1);
                    put_ch   = tcw_pkg::CH_SPACE;
                end
            end
            default:
            begin
                put_wr = 1'b1;
                if (9'(col_reg) == 9'(SCREEN_WIDTH - 1))
                begin
                    put_col = '0;
                    put_inc = 1'b1;
                end
                else
                begin
                    put_col = col_reg + CW'(1);
                end
            end
        endcase
    end

    assign need_scroll = put_inc && (line_reg == RW'(SCREEN_HEIGHT - 1));
    assign put_line    = (put_inc && !need_scroll) ? line_reg + RW'(1) : line_reg;
    // Track row * width + column by difference; a scroll keeps the line
    assign put_lin = {1'b0, lin_reg} - (AW+1)'(col_reg) + (AW+1)'(put_col)
                   + ((put_inc && !need_scroll) ? (AW+1)'(SCREEN_WIDTH) : '0);

    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        lin_next  = lin_reg;
        if (ctl.exec)
        begin
            unique case (cmd_reg)
                tcw_pkg::CMD_PUT:
                begin
                    col_next  = put_col;
                    line_next = put_line;
                    lin_next  = put_lin[AW-1:0];
                end
                tcw_pkg::CMD_SET:
                begin
                    if (in_range)
                    begin
                        col_next  = CW'(colin_reg);
                        line_next = RW'(rowin_reg);
                        lin_next  = pos_addr;
                    end
                end
                tcw_pkg::CMD_CLEAR:
                begin
                    col_next  = '0;
                    line_next = '0;
                    lin_next  = '0;
                end
                tcw_pkg::CMD_READ:
                begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    // Write queue: one cell write lands the cycle after it is queued
    always_comb
    begin
        pend_valid_next = 1'b0;
        pend_addr_next  = scan_reg;
        pend_copy_next  = 1'b0;
        pend_data_next  = {color_reg, tcw_pkg::CH_SPACE};
        unique case (ctl.step)
            tcw_pkg::STEP_COPY:
            begin
                pend_valid_next = 1'b1;
                pend_addr_next  = scan_reg - AW'(SCREEN_WIDTH);
                pend_copy_next  = 1'b1;
            end
            tcw_pkg::STEP_BLANK:
            begin
                pend_valid_next = 1'b1;
            end
            tcw_pkg::STEP_INIT:
            begin
                pend_valid_next = 1'b1;
                pend_data_next  = tcw_pkg::RESET_CELL;
            end
            tcw_pkg::STEP_NONE:
            begin
                pend_valid_next = ctl.exec && (cmd_reg == tcw_pkg::CMD_PUT) && put_wr;
                pend_addr_next  = put_addr;
                pend_data_next  = {color_reg, put_ch};
            end
        endcase
    end

    always_comb
    begin
        unique case (ctl.load)
            tcw_pkg::LOAD_ZERO:     scan_next = '0;
            tcw_pkg::LOAD_ROW1:     scan_next = AW'(SCREEN_WIDTH);
            tcw_pkg::LOAD_LAST_ROW: scan_next = AW'(CELLS - SCREEN_WIDTH);
            tcw_pkg::LOAD_NONE:
                scan_next = (ctl.step != tcw_pkg::STEP_NONE) ? scan_reg + AW'(1) : scan_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg      <= tcw_pkg::RESET_COLOR;
            col_reg        <= '0;
            line_reg       <= '0;
            lin_reg        <= '0;
            scrolled_reg   <= 1'b0;
            scan_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                color_reg <= cfg_data;
            end
            col_reg        <= col_next;
            line_reg       <= line_next;
            lin_reg        <= lin_next;
            scan_reg       <= scan_next;
            pend_valid_reg <= pend_valid_next;
            if (ctl.accept)
            begin
                scrolled_reg <= 1'b0;
            end
            else if (ctl.exec && (cmd_reg == tcw_pkg::CMD_PUT) && need_scroll)
            begin
                scrolled_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg   <= in_cmd;
            char_reg  <= in_char;
            colin_reg <= in_col;
            rowin_reg <= in_row;
        end
        pend_addr_reg <= pend_addr_next;
        pend_copy_reg <= pend_copy_next;
        pend_data_reg <= pend_data_next;
    end

    // Cell memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (pend_valid_reg)
        begin
            mem[pend_addr_reg] <= pend_copy_reg ? rd_data_reg : pend_data_reg;
        end
        if (ctl.step == tcw_pkg::STEP_COPY)
        begin
            rd_data_reg <= mem[scan_reg];
        end
        else if (ctl.read_cell)
        begin
            rd_data_reg <= mem[pos_addr];
        end
    end

    assign col_ext = CXW'(col_next);
    assign row_ext = RXW'(line_next);
    assign lin_ext = LXW'(lin_next);

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            out_col_reg      <= col_ext[tcw_pkg::COL_OUT_W-1:0];
            out_row_reg      <= row_ext[tcw_pkg::ROW_OUT_W-1:0];
            out_lin_reg      <= lin_ext[tcw_pkg::LIN_OUT_W-1:0];
            out_cell_reg     <= ((cmd_reg == tcw_pkg::CMD_READ) && in_range) ? rd_data_reg : '0;
            out_scrolled_reg <= scrolled_reg;
        end
    end

    assign sts.scan_last   = (scan_reg == AW'(CELLS - 1));
    assign sts.need_scroll = (cmd_reg == tcw_pkg::CMD_PUT) && need_scroll;
    assign sts.is_clear    = (cmd_reg == tcw_pkg::CMD_CLEAR);
    assign sts.read_hit    = (cmd_reg == tcw_pkg::CMD_READ) && in_range;

    assign cursor_col_out = out_col_reg;
    assign cursor_row_out = out_row_reg;
    assign cursor_linear  = out_lin_reg;
    assign cell_data      = out_cell_reg;
    assign scrolled       = out_scrolled_reg;

endmodule

// ===== rtl/tcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl: command sequencer
// Runs the reset clearing pass, takes one request at a time, steps the scroll,
// blank and clear sweeps and owns the result valid flag.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  tcw_pkg::dp_status_t sts,
    output tcw_pkg::ctl_cmd_t   ctl
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_BLANK,
        ST_CLEAR,
        ST_READ,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        ctl.accept    = 1'b0;
        ctl.exec      = 1'b0;
        ctl.read_cell = 1'b0;
        ctl.load_out  = 1'b0;
        ctl.step      = tcw_pkg::STEP_NONE;
        ctl.load      = tcw_pkg::LOAD_NONE;
        unique case (state_reg)
            ST_INIT:
            begin
                ctl.step = tcw_pkg::STEP_INIT;
                if (sts.scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ctl.accept = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                priority if (sts.is_clear)
                begin
                    ctl.load   = tcw_pkg::LOAD_ZERO;
                    state_next = ST_CLEAR;
                end
                else if (sts.need_scroll)
                begin
                    ctl.load   = tcw_pkg::LOAD_ROW1;
                    state_next = ST_SCROLL;
                end
                else if (sts.read_hit)
                begin
                    ctl.read_cell = 1'b1;
                    state_next    = ST_READ;
                end
                else if (out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                ctl.step = tcw_pkg::STEP_COPY;
                if (sts.scan_last)
                begin
                    ctl.load   = tcw_pkg::LOAD_LAST_ROW;
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK,
            ST_CLEAR:
            begin
                ctl.step = tcw_pkg::STEP_BLANK;
                if (sts.scan_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ,
            ST_DONE:
            begin
                if (out_free)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
        endcase
    end

    assign m_tvalid_next = ctl.load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== rtl/text_console_character_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_character_writer: text-mode console engine
// Cursor handling, character writes, scroll, clear and cell read over a
// width x height screen store of 16-bit cells (attribute high, code low).
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  s_*      in         s_tvalid / s_tready     one command request
//  m_*      out        m_tvalid / m_tready     cursor, cell and scroll result
//  cfg_*    in         cfg_valid / cfg_ready   text_color attribute byte
//
//  Put, set cursor and a read outside the screen load the result from the
//  execute state; a read on the screen passes through a read state first,
//  for the registered memory read. A scroll and a clear each sweep the
//  whole store: the single memory write port moves or blanks one cell a cycle.
//  After reset a clearing pass over the width*height cells (2000 by default)
//  runs before the first request is taken; cfg writes are taken at any time.
//  A stalled result sits in the output register while the next request is
//  taken; that request finishes only once the result has left.
// ----------------------------------------------------------------------------
module text_console_character_writer #(
    parameter int SCREEN_WIDTH  = tcw_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tcw_pkg::DEFAULT_SCREEN_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // char_code [7:0], col_in [15:8], row_in [23:16]
    input  logic [tcw_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd [1:0]
    input  logic [tcw_pkg::CMD_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // cursor_col_out [6:0], cursor_row_out [11:7], cursor_linear [22:12],
    // cell_data [38:23], scrolled [39]
    output logic [tcw_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcw_pkg::COLOR_W-1:0]     cfg_data
);

    tcw_pkg::ctl_cmd_t             ctl;
    tcw_pkg::dp_status_t           sts;
    logic [tcw_pkg::COL_OUT_W-1:0] cursor_col_out;
    logic [tcw_pkg::ROW_OUT_W-1:0] cursor_row_out;
    logic [tcw_pkg::LIN_OUT_W-1:0] cursor_linear;
    logic [tcw_pkg::CELL_W-1:0]    cell_data;
    logic                          scrolled;

    tcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    tcw_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .in_cmd         (tcw_pkg::cmd_t'(s_tuser)),
        .in_char        (s_tdata[7:0]),
        .in_col         (s_tdata[15:8]),
        .in_row         (s_tdata[23:16]),
        .ctl            (ctl),
        .sts            (sts),
        .cursor_col_out (cursor_col_out),
        .cursor_row_out (cursor_row_out),
        .cursor_linear  (cursor_linear),
        .cell_data      (cell_data),
        .scrolled       (scrolled)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = {scrolled, cell_data, cursor_linear, cursor_row_out, cursor_col_out};

endmodule

// ===== rtl/tcw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for the text console character writer
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int SCREEN_WIDTH  = tcw_pkg::DEFAULT_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tcw_pkg::DEFAULT_SCREEN_HEIGHT
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tcw_pkg::M_TDATA_W-1:0] m_tdata
);

    // hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight: no back-to-back accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while previous one still executing");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[6:0]) < SCREEN_WIDTH))
        else $error("cursor column off screen");

    // a scroll always leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[39] |-> m_tdata[11:7] == 5'(SCREEN_HEIGHT - 1))
        else $error("scroll result not on bottom row");

endmodule

bind text_console_character_writer tcw_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the text console character writer
// Drives command requests and text_color writes into the console engine and
// checks every result against a cycle-free model of the cursor and the screen
// store. The run starts with a directed set of requests that covers control
// codes, wrap, scroll and out-of-range positions. It then sends random
// traffic under several attribute settings, with random idling on both sides,
// a stretch without idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

    localparam int SCR_W        = tcw_pkg::DEFAULT_SCREEN_WIDTH;
    localparam int SCR_H        = tcw_pkg::DEFAULT_SCREEN_HEIGHT;
    localparam int SCR_CELLS    = SCR_W * SCR_H;
    localparam int IDX_W        = $clog2(SCR_CELLS);
    localparam int CELL_BITS    = tcw_pkg::CELL_W;
    localparam int PHASES       = 5;
    localparam int PH_W         = $clog2(PHASES);
    localparam int PHASE_ITEMS  = 320;
    localparam int CYCLE_LIMIT  = 6000000;
    localparam int HOLD_CYCLES  = 400;
    // a scroll or a clear sweeps the whole store once
    localparam int SETTLE_CYCLES = SCR_CELLS + 100;

    typedef struct packed {
        tcw_pkg::cmd_t                 op;
        logic [tcw_pkg::CHAR_W-1:0]    code;
        logic [7:0]                    col;
        logic [7:0]                    row;
    } console_req_t;

    // same bit order as m_tdata: col lowest, scrolled highest
    typedef struct packed {
        logic                          scrolled;
        logic [tcw_pkg::CELL_W-1:0]    cell_data;
        logic [tcw_pkg::LIN_OUT_W-1:0] linear;
        logic [tcw_pkg::ROW_OUT_W-1:0] row;
        logic [tcw_pkg::COL_OUT_W-1:0] col;
    } console_result_t;

    class console_tracker;
        logic [tcw_pkg::COLOR_W-1:0] color;
        int                          cur_col;
        int                          cur_row;
        logic [tcw_pkg::CELL_W-1:0]  cells [SCR_CELLS];
        console_result_t             expected_q [$];
        int                          errors;
        int                          n_put;
        int                          n_set;
        int                          n_clear;
        int                          n_read;
        int                          n_scroll;
        int                          n_checked;

        function new();
            color = tcw_pkg::RESET_COLOR;
            cur_col = 0;
            cur_row = 0;
            foreach (cells[i])
                cells[i] = tcw_pkg::RESET_CELL;
            errors = 0;
            n_put = 0;
            n_set = 0;
            n_clear = 0;
            n_read = 0;
            n_scroll = 0;
            n_checked = 0;
        endfunction

        function void set_color(logic [tcw_pkg::COLOR_W-1:0] c);
            color = c;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [IDX_W-1:0] cell_idx(int r, int c);
            return IDX_W'(r * SCR_W + c);
        endfunction

        // advance the cursor and the screen for one request, return its result
        function console_result_t apply_command(console_req_t req);
            console_result_t res;
            logic [tcw_pkg::CELL_W-1:0] blank;
            blank = {color, tcw_pkg::CH_SPACE};
            res = '0;
            case (req.op)
                tcw_pkg::CMD_PUT:
                begin
                    n_put++;
                    if (req.code == tcw_pkg::CH_LF)
                    begin
                        cur_col = 0;
                        cur_row++;
                    end
                    else if (req.code == tcw_pkg::CH_CR)
                        cur_col = 0;
                    else if (req.code == tcw_pkg::CH_TAB)
                    begin
                        cur_col = (cur_col + 8) & ~7;
                        if (cur_col >= SCR_W)
                        begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                    else if (req.code == tcw_pkg::CH_BS)
                    begin
                        // nothing happens at column zero
                        if (cur_col > 0)
                        begin
                            cur_col--;
                            cells[cell_idx(cur_row, cur_col)] = blank;
                        end
                    end
                    else
                    begin
                        cells[cell_idx(cur_row, cur_col)] = {color, req.code};
                        cur_col++;
                        if (cur_col >= SCR_W)
                        begin
                            cur_col = 0;
                            cur_row++;
                        end
                    end
                    if (cur_row >= SCR_H)
                    begin
                        for (int i = 0; i < SCR_CELLS - SCR_W; i++)
                            cells[cell_idx(0, i)] = cells[cell_idx(0, i + SCR_W)];
                        for (int i = SCR_CELLS - SCR_W; i < SCR_CELLS; i++)
                            cells[cell_idx(0, i)] = blank;
                        cur_row = SCR_H - 1;
                        res.scrolled = 1'b1;
                        n_scroll++;
                    end
                end
                tcw_pkg::CMD_SET:
                begin
                    n_set++;
                    if (req.col < SCR_W && req.row < SCR_H)
                    begin
                        cur_col = int'(req.col);
                        cur_row = int'(req.row);
                    end
                end
                tcw_pkg::CMD_CLEAR:
                begin
                    n_clear++;
                    foreach (cells[i])
                        cells[i] = blank;
                    cur_col = 0;
                    cur_row = 0;
                end
                default:
                begin
                    n_read++;
                    if (req.col < SCR_W && req.row < SCR_H)
                        res.cell_data = cells[cell_idx(int'(req.row), int'(req.col))];
                end
            endcase
            res.col    = cur_col[tcw_pkg::COL_OUT_W-1:0];
            res.row    = cur_row[tcw_pkg::ROW_OUT_W-1:0];
            res.linear = tcw_pkg::LIN_OUT_W'(cur_row * SCR_W + cur_col);
            return res;
        endfunction

        function void note_request(console_req_t req);
            expected_q.push_back(apply_command(req));
        endfunction

        function void compare_field(string name, logic [tcw_pkg::CELL_W-1:0] exp_v,
                                    logic [tcw_pkg::CELL_W-1:0] act_v);
            if (act_v !== exp_v)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [tcw_pkg::M_TDATA_W-1:0] data);
            console_result_t got;
            console_result_t exp_r;
            got = data;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with no request pending, actual %h", $time, data);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            n_checked++;
            compare_field("cursor_col_out", CELL_BITS'(exp_r.col), CELL_BITS'(got.col));
            compare_field("cursor_row_out", CELL_BITS'(exp_r.row), CELL_BITS'(got.row));
            compare_field("cursor_linear", CELL_BITS'(exp_r.linear),
                          CELL_BITS'(got.linear));
            compare_field("cell_data", exp_r.cell_data, got.cell_data);
            compare_field("scrolled", CELL_BITS'(exp_r.scrolled),
                          CELL_BITS'(got.scrolled));
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tcw_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [tcw_pkg::CMD_W-1:0]       s_tuser = tcw_pkg::CMD_PUT;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tcw_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [tcw_pkg::COLOR_W-1:0]     cfg_data = '0;

    console_tracker tracker = new();
    bit  steady = 1'b0;
    bit  hold_trigger = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_left = 0;
    int  cycles = 0;
    int  color_writes = 0;

    text_console_character_writer #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off, none while steady
    always @(posedge clk)
    begin
        if (hold_trigger && !hold_done)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 25);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    function automatic console_req_t make_req(tcw_pkg::cmd_t op, int code, int col,
                                              int row);
        console_req_t r;
        r.op   = op;
        r.code = code[tcw_pkg::CHAR_W-1:0];
        r.col  = col[7:0];
        r.row  = row[7:0];
        return r;
    endfunction

    function automatic console_req_t random_request();
        console_req_t r;
        int pick;
        int sub;
        r.code = 8'($urandom_range(0, 255));
        r.col  = 8'($urandom_range(0, 255));
        r.row  = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        if (pick < 55)
        begin
            r.op = tcw_pkg::CMD_PUT;
            if (sub < 8)
                r.code = tcw_pkg::CH_LF;
            else if (sub < 14)
                r.code = tcw_pkg::CH_TAB;
            else if (sub < 22)
                r.code = tcw_pkg::CH_BS;
            else if (sub < 26)
                r.code = tcw_pkg::CH_CR;
        end
        else if (pick < 68)
        begin
            r.op = tcw_pkg::CMD_SET;
            // favor the bottom rows so that scrolls come often
            if (sub >= 60)
            begin
                r.col = 8'($urandom_range(0, SCR_W - 1));
                r.row = 8'($urandom_range(0, SCR_H - 1));
            end
            else if (sub >= 20)
            begin
                r.col = 8'($urandom_range(0, SCR_W - 1));
                r.row = 8'($urandom_range(SCR_H - 2, SCR_H - 1));
            end
        end
        else if (pick < 98)
        begin
            r.op = tcw_pkg::CMD_READ;
            if (sub < 85)
            begin
                r.col = 8'($urandom_range(0, SCR_W - 1));
                r.row = 8'($urandom_range(0, SCR_H - 1));
            end
        end
        else
            r.op = tcw_pkg::CMD_CLEAR;
        return r;
    endfunction

    task automatic send_request(input console_req_t req);
        int gap;
        if (!steady && $urandom_range(0, 99) < 25)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req.op;
        s_tdata  <= {req.row, req.col, req.code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tracker.note_request(req);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_color(input logic [tcw_pkg::COLOR_W-1:0] c);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_color(c);
        color_writes++;
    endtask

    task automatic run_directed();
        send_request(make_req(tcw_pkg::CMD_READ, 0, 0, 0));
        send_request(make_req(tcw_pkg::CMD_PUT, 8'h41, 255, 255));
        send_request(make_req(tcw_pkg::CMD_PUT, 8'h00, 0, 0));
        send_request(make_req(tcw_pkg::CMD_PUT, 8'hFF, 0, 0));
        send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 0, 0));
        send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 0, 0));
        send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_CR, 0, 0));
        send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 0, 0));
        send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_LF, 0, 0));
        // tab from the last tab stop wraps to the next row
        send_request(make_req(tcw_pkg::CMD_SET, 8'hFF, 72, 5));
        send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 0, 0));
        // write into the very last cell: wrap and scroll
        send_request(make_req(tcw_pkg::CMD_SET, 0, SCR_W - 1, SCR_H - 1));
        send_request(make_req(tcw_pkg::CMD_PUT, 8'h78, 0, 0));
        send_request(make_req(tcw_pkg::CMD_READ, 0, SCR_W - 1, SCR_H - 2));
        send_request(make_req(tcw_pkg::CMD_SET, 0, SCR_W, 0));
        send_request(make_req(tcw_pkg::CMD_SET, 0, 0, SCR_H));
        send_request(make_req(tcw_pkg::CMD_SET, 0, 255, 255));
        send_request(make_req(tcw_pkg::CMD_READ, 0, SCR_W, 0));
        send_request(make_req(tcw_pkg::CMD_READ, 0, 0, SCR_H));
        send_request(make_req(tcw_pkg::CMD_READ, 8'hFF, 255, 255));
        send_request(make_req(tcw_pkg::CMD_SET, 0, 0, SCR_H - 1));
        send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_LF, 0, 0));
        send_request(make_req(tcw_pkg::CMD_SET, 0, 76, SCR_H - 1));
        send_request(make_req(tcw_pkg::CMD_PUT, tcw_pkg::CH_TAB, 0, 0));
        send_request(make_req(tcw_pkg::CMD_CLEAR, 8'hFF, 255, 255));
    endtask

    initial
    begin
        logic [tcw_pkg::COLOR_W-1:0] phase_color [PHASES];
        phase_color[0] = tcw_pkg::RESET_COLOR;
        phase_color[1] = 8'hFF;
        phase_color[2] = 8'h00;
        phase_color[3] = 8'($urandom_range(0, 255));
        phase_color[4] = 8'($urandom_range(0, 255));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int phase = 0; phase < PHASES; phase++)
        begin
            // attribute changes only with nothing in flight
            if (phase > 0)
            begin
                drain_results();
                write_color(phase_color[PH_W'(phase)]);
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                steady = (phase == 1 && i >= 50 && i < 250);
                if (phase == 2 && i == 20)
                    hold_trigger = 1'b1;
                send_request(random_request());
            end
            steady = 1'b0;
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d puts, %0d cursor sets, %0d reads, %0d clears",
                 tracker.n_checked, tracker.n_put, tracker.n_set, tracker.n_read,
                 tracker.n_clear);
        $display("Scrolls seen: %0d, attribute writes: %0d, cycles: %0d",
                 tracker.n_scroll, color_writes, cycles);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
